// File: sv/mtfrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfrl_pkg
// shared types and codes for the move-to-front recency list
// ----------------------------------------------------------------------------
package mtfrl_pkg;

  localparam int KEY_W = 50;

  typedef logic [KEY_W-1:0] key_t;

  // input item kind, carried on in_tuser
  typedef enum logic {
    CMD_ACCESS = 1'b0,
    CMD_DUMP   = 1'b1
  } cmd_kind_t;

  // controller to datapath
  typedef struct packed {
    logic access;      // look up key, move or insert at top, load access result
    logic empty_dump;  // load the single empty-dump result
    logic dump_start;  // clear the dump position
    logic dump_step;   // load top entry as a result and rotate the list by one
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic dump_last;
  } dpath_sts_t;

endpackage

// File: sv/move_to_front_recency_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_recency_list
// recency-ordered list of distinct 50-bit keys with move-to-front access
// ----------------------------------------------------------------------------
// The block holds up to ENTRIES distinct keys, most recently used on top. An
// access beat (in_tuser low) compares the key against every live cell at once
// and, in the same cycle, shifts the cells above the match (or all live cells
// on a miss) down by one and puts the key on top; it gives one result beat with
// was_hit, and evicted set when a new key pushed out the bottom entry of a full
// list. A dump beat (in_tuser high) gives one result beat per live entry, top
// first, with tlast on the bottom one; a rotate of the cell row walks the list
// through the top cell and leaves it unchanged, and each step waits until the
// output register is free. A dump of an empty list gives a single beat with
// entry_valid low. The next input beat is taken once the current item is
// finished and the output register is empty or hands its beat over in that
// same cycle; a result held by a stalled receiver holds off the input. Cells
// are not cleared by reset; only the fill count is, and no cell past the count
// is ever looked at.
// ----------------------------------------------------------------------------
module move_to_front_recency_list import mtfrl_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [49:0] key, [55:50] zero
  input  logic        in_tuser,   // command: 0 access, 1 dump
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [49:0] entry_key, [50] entry_valid,
                                  // [51] was_hit, [52] evicted, [55:53] zero
  output logic        out_tlast   // last result of the item
);

  ctrl_cmd_t  cmd;
  dpath_sts_t sts;
  cmd_kind_t  in_kind;
  key_t       res_key;
  logic       res_entry_valid;
  logic       res_was_hit;
  logic       res_evicted;
  logic       res_last;

  assign in_kind = cmd_kind_t'(in_tuser);

  // sequencing: accepts a beat, steps through a dump, owns out_tvalid
  mtfrl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_kind),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // key cells, compare and shift network, result register
  mtfrl_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_key          (in_tdata[KEY_W-1:0]),
    .cmd             (cmd),
    .sts             (sts),
    .res_key         (res_key),
    .res_entry_valid (res_entry_valid),
    .res_was_hit     (res_was_hit),
    .res_evicted     (res_evicted),
    .res_last        (res_last)
  );

  // pack result fields, lowest field first
  assign out_tdata = {3'b000, res_evicted, res_was_hit, res_entry_valid, res_key};
  assign out_tlast = res_last;

endmodule

// File: sv/mtfrl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfrl_ctrl
// handshake control and dump sequencing for the recency list
// ----------------------------------------------------------------------------
module mtfrl_ctrl import mtfrl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  cmd_kind_t  in_kind,
  output logic       out_tvalid,
  input  logic       out_tready,
  output ctrl_cmd_t  cmd,
  input  dpath_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_fire;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_kind)
            CMD_ACCESS: begin
              cmd.access    = 1'b1;
              out_valid_nxt = 1'b1;
            end
            CMD_DUMP: begin
              if (sts.count_zero) begin
                cmd.empty_dump = 1'b1;
                out_valid_nxt  = 1'b1;
              end else begin
                cmd.dump_start = 1'b1;
                state_nxt      = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.dump_step = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a finished dump always hands control back for the next item
  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP && out_free && sts.dump_last) |=> (state_r == S_IDLE))
    else $error("dump did not return to idle after last entry");

  // only one datapath command per cycle
  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command issued");

  // a new result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> (cmd.access == 1'b0 && cmd.dump_step == 1'b0
                                      && cmd.empty_dump == 1'b0))
    else $error("result register overwritten while stalled");
`endif

endmodule

// File: sv/mtfrl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfrl_dpath
// row of key cells with parallel compare, shift and rotate, plus result register
// ----------------------------------------------------------------------------
module mtfrl_dpath import mtfrl_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  key_t       in_key,
  input  ctrl_cmd_t  cmd,
  output dpath_sts_t sts,
  output key_t       res_key,
  output logic       res_entry_valid,
  output logic       res_was_hit,
  output logic       res_evicted,
  output logic       res_last
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = $clog2(ENTRIES);

  key_t             cell_r [ENTRIES];
  key_t             cell_nxt [ENTRIES];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_m1;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] shift_en;
  logic             any_hit;
  logic             full;

  key_t res_key_r, res_key_nxt;
  logic res_entry_valid_r, res_entry_valid_nxt;
  logic res_was_hit_r, res_was_hit_nxt;
  logic res_evicted_r, res_evicted_nxt;
  logic res_last_r, res_last_nxt;

  assign cnt_m1  = count_r - CNT_W'(1);
  assign any_hit = |hit_vec;
  assign full    = (count_r == CNT_W'(ENTRIES));

  assign sts.count_zero = (count_r == '0);
  assign sts.dump_last  = (CNT_W'(idx_r) == cnt_m1);

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      // only live positions take part in the lookup
      assign hit_vec[gi]  = (CNT_W'(gi) < count_r) && (cell_r[gi] == in_key);
      // move to front shifts every position at or above the match;
      // an insert shifts every live position plus the first free one
      assign shift_en[gi] = any_hit ? (|(hit_vec >> gi)) : (CNT_W'(gi) <= count_r);

      always_comb begin
        cell_nxt[gi] = cell_r[gi];
        if (cmd.access) begin
          if (gi == 0) begin
            cell_nxt[gi] = in_key;
          end else if (shift_en[gi]) begin
            cell_nxt[gi] = cell_r[(gi == 0) ? 0 : gi - 1];
          end
        end else if (cmd.dump_step) begin
          // rotate the live part up by one, top wraps to the bottom
          if (CNT_W'(gi) < cnt_m1) begin
            cell_nxt[gi] = cell_r[(gi == ENTRIES - 1) ? gi : gi + 1];
          end else if (CNT_W'(gi) == cnt_m1) begin
            cell_nxt[gi] = cell_r[0];
          end
        end
      end

      always_ff @(posedge clk) begin
        cell_r[gi] <= cell_nxt[gi];
      end
    end
  endgenerate

  always_comb begin
    count_nxt           = count_r;
    idx_nxt             = idx_r;
    res_key_nxt         = res_key_r;
    res_entry_valid_nxt = res_entry_valid_r;
    res_was_hit_nxt     = res_was_hit_r;
    res_evicted_nxt     = res_evicted_r;
    res_last_nxt        = res_last_r;
    if (cmd.access) begin
      if (!any_hit && !full) begin
        count_nxt = count_r + CNT_W'(1);
      end
      res_key_nxt         = '0;
      res_entry_valid_nxt = 1'b0;
      res_was_hit_nxt     = any_hit;
      res_evicted_nxt     = !any_hit && full;
      res_last_nxt        = 1'b1;
    end
    if (cmd.empty_dump) begin
      res_key_nxt         = '0;
      res_entry_valid_nxt = 1'b0;
      res_was_hit_nxt     = 1'b0;
      res_evicted_nxt     = 1'b0;
      res_last_nxt        = 1'b1;
    end
    if (cmd.dump_start) begin
      idx_nxt = '0;
    end
    if (cmd.dump_step) begin
      idx_nxt             = idx_r + IDX_W'(1);
      res_key_nxt         = cell_r[0];
      res_entry_valid_nxt = 1'b1;
      res_was_hit_nxt     = 1'b0;
      res_evicted_nxt     = 1'b0;
      res_last_nxt        = sts.dump_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    idx_r             <= idx_nxt;
    res_key_r         <= res_key_nxt;
    res_entry_valid_r <= res_entry_valid_nxt;
    res_was_hit_r     <= res_was_hit_nxt;
    res_evicted_r     <= res_evicted_nxt;
    res_last_r        <= res_last_nxt;
  end

  assign res_key         = res_key_r;
  assign res_entry_valid = res_entry_valid_r;
  assign res_was_hit     = res_was_hit_r;
  assign res_evicted     = res_evicted_r;
  assign res_last        = res_last_r;

`ifndef NO_ASSERTIONS
  // live keys are distinct, so a lookup matches at most one position
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.access |-> $onehot0(hit_vec))
    else $error("key found at more than one list position");

  // fill count never passes the list size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count above list size");

  // the count only moves on an access, and then by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |->
      ($past(cmd.access) && count_r == $past(count_r) + CNT_W'(1)))
    else $error("entry count changed outside an insert");
`endif

endmodule

// File: sim/mtfrl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfrl_checker
// watches both streams of the recency list, predicts each result beat and
// compares it with what comes out
// ----------------------------------------------------------------------------
module mtfrl_checker import mtfrl_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,   // [49:0] key, [55:50] zero
  input  logic        in_tuser,   // command: 0 access, 1 dump
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // [49:0] entry_key, [50] entry_valid,
                                  // [51] was_hit, [52] evicted, [55:53] zero
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    key_t key;
    logic valid;
    logic hit;
    logic evicted;
    logic last;
  } result_beat_t;

  key_t         shadow_list [ENTRIES];
  int           shadow_fill;
  result_beat_t expected_beats [$];
  int           err_total;

  task automatic report_mismatch(string what);
    err_total++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  // update the shadow list for one accepted beat and queue its results
  task automatic move_to_front_predict(cmd_kind_t kind, key_t key);
    int           pos;
    int           top;
    result_beat_t beat;
    beat = '0;
    if (kind == CMD_DUMP) begin
      if (shadow_fill == 0) begin
        beat.last = 1'b1;
        expected_beats.push_back(beat);
      end else begin
        for (int i = 0; i < shadow_fill; i++) begin
          beat.key   = shadow_list[i];
          beat.valid = 1'b1;
          beat.last  = (i == shadow_fill - 1);
          expected_beats.push_back(beat);
        end
      end
    end else begin
      pos = shadow_fill;
      for (int i = 0; i < shadow_fill; i++) begin
        if (pos == shadow_fill && shadow_list[i] == key) pos = i;
      end
      beat.last = 1'b1;
      if (pos < shadow_fill) begin
        beat.hit = 1'b1;
        top = pos;
      end else if (shadow_fill == ENTRIES) begin
        // full list: bottom entry falls off
        beat.evicted = 1'b1;
        top = ENTRIES - 1;
      end else begin
        top = shadow_fill;
        shadow_fill++;
      end
      for (int i = top; i > 0; i--) shadow_list[i] = shadow_list[i-1];
      shadow_list[0] = key;
      expected_beats.push_back(beat);
    end
  endtask

  task automatic check_result_beat();
    result_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("result beat with nothing expected");
    end else begin
      want = expected_beats.pop_front();
      check_field("entry_key", out_tdata[KEY_W-1:0], want.key);
      check_field("entry_valid", KEY_W'(out_tdata[50]), KEY_W'(want.valid));
      check_field("was_hit", KEY_W'(out_tdata[51]), KEY_W'(want.hit));
      check_field("evicted", KEY_W'(out_tdata[52]), KEY_W'(want.evicted));
      check_field("tlast", KEY_W'(out_tlast), KEY_W'(want.last));
    end
  endtask

  // input side first so a result can never overtake its own prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_fill = 0;
      expected_beats.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        move_to_front_predict(cmd_kind_t'(in_tuser), in_tdata[KEY_W-1:0]);
      end
      if (out_tvalid && out_tready) check_result_beat();
    end
    mismatches  <= err_total;
    outstanding <= expected_beats.size();
  end

endmodule

// File: sim/tb_move_to_front_recency_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_move_to_front_recency_list
// drives access and dump beats into the recency list with random idling on
// both streams; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_move_to_front_recency_list;
  import mtfrl_pkg::*;

  localparam int ENTRIES     = 32;
  localparam int POOL        = 48;
  localparam int QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;

  int   send_idle_pct;
  int   recv_stall_pct;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles;
  key_t key_pool [POOL];
  key_t odd_codes;

  move_to_front_recency_list #(.ENTRIES(ENTRIES)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  mtfrl_checker #(.ENTRIES(ENTRIES)) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ends the run when neither stream moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic key_t raw_key();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[KEY_W-1:0];
  endfunction

  // name of one to ten letters a..z, five bits per letter
  function automatic key_t name_key();
    key_t k;
    int   len;
    k   = '0;
    len = $urandom_range(10, 1);
    for (int i = 0; i < len; i++) k[i*5 +: 5] = 5'($urandom_range(26, 1));
    return k;
  endfunction

  task automatic send_beat(cmd_kind_t kind, key_t key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // mostly keys from a pool so hits, fills and evictions happen
  task automatic random_item(int span);
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      send_beat(CMD_DUMP, raw_key());
    end else if (r < 22) begin
      send_beat(CMD_ACCESS, raw_key());
    end else begin
      send_beat(CMD_ACCESS, key_pool[$urandom_range(span - 1)]);
    end
  endtask

  initial begin
    send_idle_pct  = 35;
    recv_stall_pct = 54;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL; i++) key_pool[i] = (i % 2) ? name_key() : raw_key();
    odd_codes = '0;
    odd_codes[24:0] = {5'd31, 5'd30, 5'd29, 5'd28, 5'd27};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty dumps, zero and all-ones keys, hits at top and bottom,
    // letter codes above the alphabet, single-bit keys
    send_beat(CMD_DUMP, '0);
    send_beat(CMD_DUMP, '1);
    send_beat(CMD_ACCESS, '0);
    send_beat(CMD_ACCESS, '1);
    send_beat(CMD_ACCESS, '0);
    send_beat(CMD_ACCESS, '0);
    send_beat(CMD_ACCESS, odd_codes);
    send_beat(CMD_ACCESS, name_key());
    send_beat(CMD_ACCESS, key_t'(1));
    send_beat(CMD_ACCESS, key_t'(1) << (KEY_W - 1));
    send_beat(CMD_DUMP, raw_key());
    send_beat(CMD_ACCESS, '1);
    send_beat(CMD_ACCESS, odd_codes);
    send_beat(CMD_DUMP, '0);
    send_beat(CMD_ACCESS, key_t'(1) << (KEY_W - 1));
    send_beat(CMD_DUMP, '1);

    for (int n = 0; n < 100; n++) random_item(POOL);
    send_idle_pct  = 54;
    recv_stall_pct = 35;
    for (int n = 0; n < 90; n++) random_item(12);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 90; n++) random_item(POOL);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mtfrl_pkg.sv
sv/mtfrl_ctrl.sv
sv/mtfrl_dpath.sv
sv/move_to_front_recency_list.sv
sim/mtfrl_checker.sv
sim/tb_move_to_front_recency_list.sv
